@@ sv/button_accordion_note_mapper_macros.svh @@
// ----------------------------------------------------------------------------
// Button accordion note mapper assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_ACCORDION_NOTE_MAPPER_MACROS_SVH
`define BUTTON_ACCORDION_NOTE_MAPPER_MACROS_SVH

// Same-cycle implication.
`define BAN_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("note mapper check failed");

// Next-cycle implication.
`define BAN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("note mapper check failed");

`endif

@@ sv/ban_pkg.sv @@
// ----------------------------------------------------------------------------
// Button accordion note mapper package
// Event codes, channel numbers, pitch tables and controller/datapath types.
// ----------------------------------------------------------------------------
package ban_pkg;

  localparam logic [1:0] OP_BELLOWS = 2'd0;
  localparam logic [1:0] OP_BASS    = 2'd1;
  localparam logic [1:0] OP_CHORD   = 2'd2;
  localparam logic [1:0] OP_TREBLE  = 2'd3;

  localparam logic [1:0] CH_TREBLE = 2'd0;
  localparam logic [1:0] CH_BASS   = 2'd1;
  localparam logic [1:0] CH_CHORD  = 2'd2;

  localparam logic [1:0] CFG_KEY      = 2'd0;
  localparam logic [1:0] CFG_LAYOUT   = 2'd1;
  localparam logic [1:0] CFG_REVERSE  = 2'd2;
  localparam logic [1:0] CFG_VELOCITY = 2'd3;

  localparam logic [2:0] KEY_MAX   = 3'd6;
  localparam logic [3:0] ROW_LAST  = 4'd11;

  // Key offsets in 7-bit two's complement, so the add wraps modulo 128.
  localparam logic [6:0] KEY_OFFSET [7] = '{
    7'(3), 7'(-2), 7'(5), 7'(0), 7'(-5), 7'(2), 7'(-3)
  };

  // Indexed [layout][row][bellows direction].
  localparam logic [6:0] TREBLE_NOTE [2][12][2] = '{
    '{'{7'd48, 7'd53}, '{7'd52, 7'd57}, '{7'd55, 7'd59}, '{7'd60, 7'd62},
      '{7'd64, 7'd65}, '{7'd67, 7'd69}, '{7'd72, 7'd71}, '{7'd76, 7'd74},
      '{7'd79, 7'd77}, '{7'd84, 7'd81}, '{7'd88, 7'd83}, '{7'd91, 7'd86}},
    '{'{7'd48, 7'd53}, '{7'd52, 7'd55}, '{7'd55, 7'd59}, '{7'd60, 7'd62},
      '{7'd64, 7'd65}, '{7'd67, 7'd69}, '{7'd72, 7'd71}, '{7'd76, 7'd74},
      '{7'd79, 7'd77}, '{7'd84, 7'd81}, '{7'd88, 7'd83}, '{7'd91, 7'd86}}
  };

  // Indexed [key][bellows direction].
  localparam logic [6:0] BASS_NOTE [7][2] = '{
    '{7'd39, 7'd46}, '{7'd46, 7'd41}, '{7'd41, 7'd36}, '{7'd36, 7'd43},
    '{7'd43, 7'd38}, '{7'd38, 7'd45}, '{7'd45, 7'd40}
  };

  // Indexed [key][chord note][bellows direction].
  localparam logic [6:0] CHORD_NOTE [7][2][2] = '{
    '{'{7'd63, 7'd70}, '{7'd70, 7'd65}}, '{'{7'd70, 7'd65}, '{7'd65, 7'd60}},
    '{'{7'd65, 7'd60}, '{7'd60, 7'd67}}, '{'{7'd60, 7'd67}, '{7'd67, 7'd62}},
    '{'{7'd67, 7'd62}, '{7'd62, 7'd69}}, '{'{7'd62, 7'd69}, '{7'd69, 7'd64}},
    '{'{7'd69, 7'd64}, '{7'd64, 7'd71}}
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_BASS_OFF,
    ST_BASS_ON,
    ST_CHORD_OFF0,
    ST_CHORD_OFF1,
    ST_CHORD_ON0,
    ST_CHORD_ON1,
    ST_SCAN,
    ST_TREB_OFF,
    ST_TREB_ON,
    ST_BASS_ONE,
    ST_CHORD_ONE0,
    ST_CHORD_ONE1,
    ST_TREB_ONE
  } ban_state_t;

  typedef struct packed {
    logic       capture;
    logic       flip_bellows;
    logic       flip_bass;
    logic       flip_chord;
    logic       flip_button;
    logic       idx_clear;
    logic       idx_inc;
    logic       emit;
    logic       on;
    logic [1:0] chan;
    logic       chord_sel;
    logic       dir_old;
    logic       last;
  } ban_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       pressed;
    logic       bellows;
    logic       bass_held;
    logic       chord_held;
    logic       pos_ok;
    logic       btn_held;
    logic       cur_held;
    logic       any_held;
    logic       above_held;
    logic       idx_last;
    logic       out_free;
  } ban_status_t;

endpackage

@@ sv/ban_ctrl.sv @@
// ----------------------------------------------------------------------------
// Note mapper controller
// Sequences the result transactions of one event and the state updates.
// ----------------------------------------------------------------------------
module ban_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ban_pkg::ban_status_t st,
  output ban_pkg::ban_cmd_t    cmd
);

  ban_pkg::ban_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ban_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ban_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = ban_pkg::ST_DISPATCH;
      end
      ban_pkg::ST_DISPATCH: begin
        state_nxt = ban_pkg::ST_IDLE;
        unique case (st.op)
          ban_pkg::OP_BELLOWS: begin
            if (st.pressed != st.bellows) begin
              if (st.bass_held)       state_nxt = ban_pkg::ST_BASS_OFF;
              else if (st.chord_held) state_nxt = ban_pkg::ST_CHORD_OFF0;
              else                    state_nxt = ban_pkg::ST_SCAN;
            end
          end
          ban_pkg::OP_BASS: begin
            if (st.pressed != st.bass_held) state_nxt = ban_pkg::ST_BASS_ONE;
          end
          ban_pkg::OP_CHORD: begin
            if (st.pressed != st.chord_held) state_nxt = ban_pkg::ST_CHORD_ONE0;
          end
          default: begin
            if (st.pos_ok && (st.pressed != st.btn_held)) state_nxt = ban_pkg::ST_TREB_ONE;
          end
        endcase
      end
      ban_pkg::ST_BASS_OFF: begin
        if (st.out_free) state_nxt = ban_pkg::ST_BASS_ON;
      end
      ban_pkg::ST_BASS_ON: begin
        if (st.out_free) state_nxt = st.chord_held ? ban_pkg::ST_CHORD_OFF0 : ban_pkg::ST_SCAN;
      end
      ban_pkg::ST_CHORD_OFF0: begin
        if (st.out_free) state_nxt = ban_pkg::ST_CHORD_OFF1;
      end
      ban_pkg::ST_CHORD_OFF1: begin
        if (st.out_free) state_nxt = ban_pkg::ST_CHORD_ON0;
      end
      ban_pkg::ST_CHORD_ON0: begin
        if (st.out_free) state_nxt = ban_pkg::ST_CHORD_ON1;
      end
      ban_pkg::ST_CHORD_ON1: begin
        if (st.out_free) state_nxt = ban_pkg::ST_SCAN;
      end
      ban_pkg::ST_SCAN: begin
        if (st.cur_held)      state_nxt = ban_pkg::ST_TREB_OFF;
        else if (st.idx_last) state_nxt = ban_pkg::ST_IDLE;
      end
      ban_pkg::ST_TREB_OFF: begin
        if (st.out_free) state_nxt = ban_pkg::ST_TREB_ON;
      end
      ban_pkg::ST_TREB_ON: begin
        if (st.out_free) state_nxt = st.idx_last ? ban_pkg::ST_IDLE : ban_pkg::ST_SCAN;
      end
      ban_pkg::ST_BASS_ONE: begin
        if (st.out_free) state_nxt = ban_pkg::ST_IDLE;
      end
      ban_pkg::ST_CHORD_ONE0: begin
        if (st.out_free) state_nxt = ban_pkg::ST_CHORD_ONE1;
      end
      ban_pkg::ST_CHORD_ONE1: begin
        if (st.out_free) state_nxt = ban_pkg::ST_IDLE;
      end
      ban_pkg::ST_TREB_ONE: begin
        if (st.out_free) state_nxt = ban_pkg::ST_IDLE;
      end
      default: state_nxt = ban_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ban_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ban_pkg::ST_DISPATCH: begin
        unique case (st.op)
          ban_pkg::OP_BELLOWS: begin
            cmd.flip_bellows = (st.pressed != st.bellows);
            cmd.idx_clear    = 1'b1;
          end
          ban_pkg::OP_BASS:  cmd.flip_bass  = (st.pressed != st.bass_held);
          ban_pkg::OP_CHORD: cmd.flip_chord = (st.pressed != st.chord_held);
          default: cmd.flip_button = st.pos_ok && (st.pressed != st.btn_held);
        endcase
      end
      ban_pkg::ST_BASS_OFF: begin
        cmd.emit    = st.out_free;
        cmd.chan    = ban_pkg::CH_BASS;
        cmd.dir_old = 1'b1;
      end
      ban_pkg::ST_BASS_ON: begin
        cmd.emit = st.out_free;
        cmd.on   = 1'b1;
        cmd.chan = ban_pkg::CH_BASS;
        cmd.last = !st.chord_held && !st.any_held;
      end
      ban_pkg::ST_CHORD_OFF0, ban_pkg::ST_CHORD_OFF1: begin
        cmd.emit      = st.out_free;
        cmd.chan      = ban_pkg::CH_CHORD;
        cmd.chord_sel = (state_r == ban_pkg::ST_CHORD_OFF1);
        cmd.dir_old   = 1'b1;
      end
      ban_pkg::ST_CHORD_ON0, ban_pkg::ST_CHORD_ON1: begin
        cmd.emit      = st.out_free;
        cmd.on        = 1'b1;
        cmd.chan      = ban_pkg::CH_CHORD;
        cmd.chord_sel = (state_r == ban_pkg::ST_CHORD_ON1);
        cmd.last      = (state_r == ban_pkg::ST_CHORD_ON1) && !st.any_held;
      end
      ban_pkg::ST_SCAN: begin
        cmd.idx_inc = !st.cur_held && !st.idx_last;
      end
      ban_pkg::ST_TREB_OFF: begin
        cmd.emit    = st.out_free;
        cmd.chan    = ban_pkg::CH_TREBLE;
        cmd.dir_old = 1'b1;
      end
      ban_pkg::ST_TREB_ON: begin
        cmd.emit    = st.out_free;
        cmd.on      = 1'b1;
        cmd.chan    = ban_pkg::CH_TREBLE;
        cmd.last    = !st.above_held;
        cmd.idx_inc = st.out_free && !st.idx_last;
      end
      ban_pkg::ST_BASS_ONE: begin
        cmd.emit = st.out_free;
        cmd.on   = st.pressed;
        cmd.chan = ban_pkg::CH_BASS;
        cmd.last = 1'b1;
      end
      ban_pkg::ST_CHORD_ONE0, ban_pkg::ST_CHORD_ONE1: begin
        cmd.emit      = st.out_free;
        cmd.on        = st.pressed;
        cmd.chan      = ban_pkg::CH_CHORD;
        cmd.chord_sel = (state_r == ban_pkg::ST_CHORD_ONE1);
        cmd.last      = (state_r == ban_pkg::ST_CHORD_ONE1);
      end
      ban_pkg::ST_TREB_ONE: begin
        cmd.emit = st.out_free;
        cmd.on   = st.pressed;
        cmd.chan = ban_pkg::CH_TREBLE;
        cmd.last = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

@@ sv/ban_datapath.sv @@
// ----------------------------------------------------------------------------
// Note mapper datapath
// Settings, held-note state, button pointer, pitch lookup and output register.
// ----------------------------------------------------------------------------
module ban_datapath #(
  parameter int NUM_BUTTONS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_index,
  input  logic [6:0]           cfg_wdata,
  input  logic [7:0]           in_tdata,
  input  logic [1:0]           in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,
  output logic [1:0]           out_tuser,
  output logic                 out_tlast,
  input  ban_pkg::ban_cmd_t    cmd,
  output ban_pkg::ban_status_t st
);

  localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  logic [2:0]             key_r;
  logic                   layout_r;
  logic                   reverse_r;
  logic [6:0]             velocity_r;

  logic [1:0]             op_r;
  logic                   pressed_r;
  logic [3:0]             pos_r;

  logic [NUM_BUTTONS-1:0] held_r;
  logic                   bellows_r;
  logic                   bass_r;
  logic                   chord_r;
  logic [IDX_W-1:0]       idx_r;

  logic                   out_valid_r;
  logic [15:0]            out_data_r;
  logic [1:0]             out_user_r;
  logic                   out_last_r;

  logic [2:0]             key_eff;
  logic [3:0]             btn_full;
  logic [IDX_W-1:0]       btn_idx;
  logic [4:0]             row_ext;
  logic [3:0]             row;
  logic                   dir;
  logic [6:0]             note;
  logic                   out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r      <= 3'd3;
      layout_r   <= 1'b1;
      reverse_r  <= 1'b0;
      velocity_r <= 7'd127;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ban_pkg::CFG_KEY:      key_r      <= cfg_wdata[2:0];
        ban_pkg::CFG_LAYOUT:   layout_r   <= cfg_wdata[0];
        ban_pkg::CFG_REVERSE:  reverse_r  <= cfg_wdata[0];
        ban_pkg::CFG_VELOCITY: velocity_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r      <= in_tuser;
      pressed_r <= in_tdata[0];
      pos_r     <= in_tdata[4:1];
    end
  end

  // Key position to button number; mirrored unless direct order is selected.
  assign btn_full = reverse_r ? pos_r : (4'(NUM_BUTTONS - 1) - pos_r);
  assign btn_idx  = btn_full[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r    <= '0;
      bellows_r <= 1'b0;
      bass_r    <= 1'b0;
      chord_r   <= 1'b0;
    end else begin
      if (cmd.flip_bellows) bellows_r <= ~bellows_r;
      if (cmd.flip_bass)    bass_r    <= ~bass_r;
      if (cmd.flip_chord)   chord_r   <= ~chord_r;
      if (cmd.flip_button)  held_r[btn_idx] <= ~held_r[btn_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flip_button) begin
      idx_r <= btn_idx;
    end else if (cmd.idx_clear) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  assign key_eff = (key_r > ban_pkg::KEY_MAX) ? ban_pkg::KEY_MAX : key_r;
  assign row_ext = 5'(idx_r);
  assign row     = (row_ext > 5'(ban_pkg::ROW_LAST)) ? ban_pkg::ROW_LAST : row_ext[3:0];
  assign dir     = cmd.dir_old ? ~bellows_r : bellows_r;

  always_comb begin
    case (cmd.chan)
      ban_pkg::CH_BASS:  note = ban_pkg::BASS_NOTE[key_eff][dir];
      ban_pkg::CH_CHORD: note = ban_pkg::CHORD_NOTE[key_eff][cmd.chord_sel][dir];
      default: note = ban_pkg::TREBLE_NOTE[layout_r][row][dir] + ban_pkg::KEY_OFFSET[key_eff];
    endcase
  end

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= {1'b0, (cmd.on ? velocity_r : 7'd0), note, cmd.on};
      out_user_r <= cmd.chan;
      out_last_r <= cmd.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    st            = '0;
    st.op         = op_r;
    st.pressed    = pressed_r;
    st.bellows    = bellows_r;
    st.bass_held  = bass_r;
    st.chord_held = chord_r;
    st.pos_ok     = (5'(pos_r) < 5'(NUM_BUTTONS));
    st.btn_held   = held_r[btn_idx];
    st.cur_held   = held_r[idx_r];
    st.any_held   = |held_r;
    st.above_held = |((held_r >> idx_r) >> 1);
    st.idx_last   = (idx_r == IDX_W'(NUM_BUTTONS - 1));
    st.out_free   = out_free;
  end

endmodule

@@ sv/button_accordion_note_mapper.sv @@
// A result is registered once the event is captured, dispatched and emitted; in a bellows
// reversal the treble results wait for the scan to reach each held button.
// Events are handled one at a time; a bellows reversal emits one note-off and one note-on
// per held note (up to 30 results) and scans every treble button, longer while the output stalls.
// Reset (synchronous, rst_n low) releases all notes and loads the default settings.
// ----------------------------------------------------------------------------
// Button accordion note mapper
// Turns button and bellows events into note-on and note-off transactions.
// ----------------------------------------------------------------------------
module button_accordion_note_mapper #(
  parameter int NUM_BUTTONS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] pressed, [4:1] key_position, [7:5] zero
  input  logic [1:0]  in_tuser,   // [1:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] note_on, [7:1] note_number,
                                  // [14:8] note_velocity, [15] zero
  output logic [1:0]  out_tuser,  // [1:0] channel
  output logic        out_tlast
);

  ban_pkg::ban_cmd_t    cmd;
  ban_pkg::ban_status_t st;

  ban_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  ban_datapath #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .st         (st)
  );

endmodule

@@ sv/ban_checker.sv @@
// ----------------------------------------------------------------------------
// Note mapper port checker
// Watches the top-level ports over time and flags misbehavior.
// ----------------------------------------------------------------------------
`include "button_accordion_note_mapper_macros.svh"

module ban_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // A stalled result must hold still.
  `BAN_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // Events are handled one at a time, so no transaction directly follows another.
  `BAN_ASSERT_NEXT(a_in_gap, in_tvalid && in_tready, !in_tready)

  // A note-off carries zero velocity.
  `BAN_ASSERT_NOW(a_off_vel, out_tvalid && !out_tdata[0], out_tdata[14:8] == 7'd0)

  // Only the treble, bass and chord channels are used.
  `BAN_ASSERT_NOW(a_chan, out_tvalid, out_tuser <= ban_pkg::CH_CHORD)

endmodule

bind button_accordion_note_mapper ban_checker u_ban_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
